>>> sv/smdu_pkg.sv
package smdu_pkg;

  localparam int OPERAND_WIDTH   = 16;
  localparam int RESULT_WIDTH    = 2 * OPERAND_WIDTH;
  // restoring divide steps done in each pipeline stage
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = (OPERAND_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  // dividend padded with leading zeros to a whole number of stages
  localparam int DVD_WIDTH       = DIV_STAGES * STEPS_PER_STAGE;
  // input stage, divide stages, output stage
  localparam int LATENCY         = DIV_STAGES + 2;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_kind_t;

  typedef struct packed {
    logic                      valid;
    op_kind_t                  kind;
    logic                      neg;
    logic                      dz;
    logic [OPERAND_WIDTH-1:0]  divisor;
    logic [OPERAND_WIDTH-1:0]  rem;
    logic [DVD_WIDTH-1:0]      quo;
    logic [RESULT_WIDTH-1:0]   prod;
  } pipe_t;

endpackage

>>> sv/smdu_front.sv
module smdu_front
  import smdu_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            kind,
  input  logic signed [OPERAND_WIDTH-1:0] operand_a,
  input  logic        [OPERAND_WIDTH-1:0] operand_b,
  output pipe_t                           out_s
);

  pipe_t                          nxt;
  logic        [OPERAND_WIDTH-1:0] mag;
  logic signed [RESULT_WIDTH-1:0]  prod_s;

  always_comb begin
    // magnitude of the most negative value still fits unsigned
    mag    = operand_a[OPERAND_WIDTH-1] ? (OPERAND_WIDTH'(0) - operand_a) : operand_a;
    prod_s = operand_a * $signed(operand_b);
    nxt.valid   = start;
    nxt.kind    = op_kind_t'(kind);
    nxt.neg     = operand_a[OPERAND_WIDTH-1];
    nxt.dz      = (operand_b == '0);
    nxt.divisor = operand_b;
    nxt.rem     = '0;
    nxt.quo     = DVD_WIDTH'(mag);
    nxt.prod    = prod_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_s <= '0;
    end else begin
      out_s <= nxt;
    end
  end

endmodule

>>> sv/smdu_div_stage.sv
module smdu_div_stage
  import smdu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  pipe_t in_s,
  output pipe_t out_s
);

  pipe_t                  cur;
  logic [OPERAND_WIDTH:0] trial;

  // quotient bits shift in where dividend bits shift out
  always_comb begin
    cur   = in_s;
    trial = '0;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      trial   = {cur.rem, cur.quo[DVD_WIDTH-1]};
      cur.quo = {cur.quo[DVD_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, cur.divisor}) begin
        trial      = trial - {1'b0, cur.divisor};
        cur.quo[0] = 1'b1;
      end
      cur.rem = trial[OPERAND_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_s <= '0;
    end else begin
      out_s <= cur;
    end
  end

endmodule

>>> sv/smdu_back.sv
module smdu_back
  import smdu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_t                   in_s,
  output logic                    done,
  output logic [RESULT_WIDTH-1:0] result
);

  logic [OPERAND_WIDTH-1:0] q;
  logic [OPERAND_WIDTH-1:0] r;
  logic [RESULT_WIDTH-1:0]  result_next;

  always_comb begin
    q = in_s.quo[OPERAND_WIDTH-1:0];
    r = in_s.rem;
    // quotient and remainder both take the dividend's sign
    if (in_s.neg) begin
      q = OPERAND_WIDTH'(0) - q;
      r = OPERAND_WIDTH'(0) - r;
    end
    unique case (in_s.kind)
      OP_MUL:  result_next = in_s.prod;
      OP_DIV:  result_next = in_s.dz ? '0 : {r, q};
      default: result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_s.valid;
    end
    result <= result_next;
  end

endmodule

>>> sv/signed_mul_div_unit_16bit.sv
// signed 16x16 multiply / signed-by-unsigned divide unit
//
// request channel: start with kind, operand_a, operand_b is taken at any
// rising edge where busy is low; busy is always low, so a new request can
// be issued every cycle.
// kind 0: full 32-bit signed product of operand_a and operand_b.
// kind 1: operand_a (signed) divided by operand_b (unsigned), truncating
// toward zero; remainder in result[31:16], quotient in result[15:0];
// a zero divisor gives 0.
// result channel: done is high for one cycle with result; results come
// out in request order.
// pipeline: input stage with the multiplier, four divide stages of four
// restoring steps each, output stage with sign fixup. throughput: one
// request per cycle.
// reset clears all pipeline valid bits; requests in flight are dropped.
// the receiver cannot stall, so the pipeline never holds.
module signed_mul_div_unit_16bit
  import smdu_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic signed [OPERAND_WIDTH-1:0] operand_a,
  input  logic        [OPERAND_WIDTH-1:0] operand_b,
  output logic                            done,
  output logic        [RESULT_WIDTH-1:0]  result
);

  pipe_t stg [DIV_STAGES+1];

  assign busy = 1'b0;

  smdu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_s     (stg[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    smdu_div_stage u_stage (
      .clk   (clk),
      .rst   (rst),
      .in_s  (stg[g]),
      .out_s (stg[g+1])
    );
  end

  smdu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .in_s   (stg[DIV_STAGES]),
    .done   (done),
    .result (result)
  );

endmodule

>>> sv/smdu_checker.sv
module smdu_checker
  import smdu_pkg::*;
(
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            kind,
  input logic signed [OPERAND_WIDTH-1:0] operand_a,
  input logic        [OPERAND_WIDTH-1:0] operand_b,
  input logic                            done,
  input logic        [RESULT_WIDTH-1:0]  result
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every request returns exactly after the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request lost");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  a_mul_value: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !kind) |-> ##LATENCY
      (result == ({{OPERAND_WIDTH{$past(operand_a[OPERAND_WIDTH-1], LATENCY)}},
                   $past(operand_a, LATENCY)} *
                  {{OPERAND_WIDTH{$past(operand_b[OPERAND_WIDTH-1], LATENCY)}},
                   $past(operand_b, LATENCY)})))
    else $error("wrong product");

  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind && (operand_b == '0)) |-> ##LATENCY (result == '0))
    else $error("zero divisor result not zero");

endmodule

bind signed_mul_div_unit_16bit smdu_checker u_chk (.*);
